// File: rtl/pf_pkg.sv
// shared types, constants and helpers for the playfair digraph cipher core
// no dependencies; imported by every module of the block
package pf_pkg;

  localparam int SIDE       = 5;
  localparam int CELLS      = SIDE * SIDE;
  localparam int CODE_W     = 5;
  localparam int POS_W      = 3;
  localparam int CELL_IDX_W = 5;
  localparam int WR_DATA_W  = 50;
  localparam int WR_INDEX_W = 2;

  localparam logic [CODE_W-1:0] LETTER_I = CODE_W'(8);
  localparam logic [CODE_W-1:0] LETTER_J = CODE_W'(9);

  typedef enum logic [WR_INDEX_W-1:0] {
    REG_ROWS_0_1  = 2'd0,
    REG_ROWS_2_3  = 2'd1,
    REG_ROW_4     = 2'd2,
    REG_DIRECTION = 2'd3
  } reg_index_t;

  typedef enum logic {
    DIR_ENCRYPT = 1'b0,
    DIR_DECRYPT = 1'b1
  } direction_t;

  // cell (r,c) lives at index r*SIDE+c
  typedef logic [CELLS-1:0][CODE_W-1:0] square_t;

  typedef struct packed {
    logic [CODE_W-1:0] first_letter;
    logic [CODE_W-1:0] second_letter;
  } letter_pair_t;

  typedef struct packed {
    logic [CODE_W-1:0] first_result;
    logic [CODE_W-1:0] second_result;
    logic              letter_absent;
  } result_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } lane_pos_t;

  // one position forward or back, wrapping round the side
  function automatic logic [POS_W-1:0] wrap_step(input logic [POS_W-1:0] pos,
                                                 input direction_t dir);
    logic [POS_W-1:0] nxt;
    if (dir == DIR_DECRYPT) begin
      nxt = (pos == '0) ? POS_W'(SIDE - 1) : pos - POS_W'(1);
    end else begin
      nxt = (pos == POS_W'(SIDE - 1)) ? '0 : pos + POS_W'(1);
    end
    return nxt;
  endfunction

  function automatic logic [CODE_W-1:0] cell_at(input square_t sq,
                                                input logic [POS_W-1:0] row,
                                                input logic [POS_W-1:0] col);
    logic [CELL_IDX_W-1:0] idx;
    idx = CELL_IDX_W'(row) * CELL_IDX_W'(SIDE) + CELL_IDX_W'(col);
    return sq[idx];
  endfunction

endpackage

// File: rtl/playfair_digraph_cipher_core.sv
// top level of the playfair digraph cipher: key square registers, two lanes, merge
// depends on pf_pkg, pf_locate_lane and pf_merge
//
//   channel  handshake            payload
//   input    start, busy          pair   (letter_pair_t)
//   output   done (one cycle)     result (result_t)
//   config   wr_en                wr_index, wr_data
//
// a pair is taken on every cycle that start is high; busy never rises
// each result is registered by the lane compare stage and then by the merge stage,
// one register each
// rst is synchronous and clears the square, the direction and the strobes
// the receiver cannot stall: done lasts one cycle and the beat is gone after it
module playfair_digraph_cipher_core import pf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  letter_pair_t          pair,
  output logic                  done,
  output result_t               result,
  input  logic                  wr_en,
  input  logic [WR_INDEX_W-1:0] wr_index,
  input  logic [WR_DATA_W-1:0]  wr_data
);

  logic [2*SIDE*CODE_W-1:0] square_rows_0_1;
  logic [2*SIDE*CODE_W-1:0] square_rows_2_3;
  logic [SIDE*CODE_W-1:0]   square_row_4;
  direction_t               direction;
  square_t                  square;
  lane_pos_t                pos_a;
  lane_pos_t                pos_b;
  logic                     lane_valid;

  assign busy   = 1'b0;
  assign square = square_t'({square_row_4, square_rows_2_3, square_rows_0_1});

  always_ff @(posedge clk) begin
    if (rst) begin
      square_rows_0_1 <= '0;
      square_rows_2_3 <= '0;
      square_row_4    <= '0;
      direction       <= DIR_ENCRYPT;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_ROWS_0_1:  square_rows_0_1 <= wr_data[2*SIDE*CODE_W-1:0];
        REG_ROWS_2_3:  square_rows_2_3 <= wr_data[2*SIDE*CODE_W-1:0];
        REG_ROW_4:     square_row_4    <= wr_data[SIDE*CODE_W-1:0];
        REG_DIRECTION: direction       <= direction_t'(wr_data[0]);
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      lane_valid <= start && !busy;
      done       <= lane_valid;
    end
  end

  pf_locate_lane u_lane_a (
    .clk    (clk),
    .letter (pair.first_letter),
    .square (square),
    .pos    (pos_a)
  );

  pf_locate_lane u_lane_b (
    .clk    (clk),
    .letter (pair.second_letter),
    .square (square),
    .pos    (pos_b)
  );

  pf_merge u_merge (
    .clk    (clk),
    .pos_a  (pos_a),
    .pos_b  (pos_b),
    .square (square),
    .dir    (direction),
    .result (result)
  );

endmodule

// File: rtl/pf_locate_lane.sv
// one search lane: finds a letter in the key square and registers its position
// depends on pf_pkg
module pf_locate_lane import pf_pkg::*; (
  input  logic              clk,
  input  logic [CODE_W-1:0] letter,
  input  square_t           square,
  output lane_pos_t         pos
);

  logic [CODE_W-1:0] key;
  lane_pos_t         pos_next;

  assign key = (letter == LETTER_J) ? LETTER_I : letter;

  // last match in row-major order wins
  always_comb begin
    pos_next = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (square[r*SIDE + c] == key) begin
          pos_next.found = 1'b1;
          pos_next.row   = POS_W'(r);
          pos_next.col   = POS_W'(c);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
  end

endmodule

// File: rtl/pf_merge.sv
// merging stage: applies the row, column or rectangle rule to both lane positions, or flags an absent letter
// depends on pf_pkg
module pf_merge import pf_pkg::*; (
  input  logic       clk,
  input  lane_pos_t  pos_a,
  input  lane_pos_t  pos_b,
  input  square_t    square,
  input  direction_t dir,
  output result_t    result
);

  result_t result_next;

  always_comb begin
    result_next = '0;
    if (!pos_a.found || !pos_b.found) begin
      result_next.letter_absent = 1'b1;
    end else if (pos_a.row == pos_b.row) begin
      // also covers both letters in the same cell
      result_next.first_result  = cell_at(square, pos_a.row, wrap_step(pos_a.col, dir));
      result_next.second_result = cell_at(square, pos_b.row, wrap_step(pos_b.col, dir));
    end else if (pos_a.col == pos_b.col) begin
      result_next.first_result  = cell_at(square, wrap_step(pos_a.row, dir), pos_a.col);
      result_next.second_result = cell_at(square, wrap_step(pos_b.row, dir), pos_b.col);
    end else begin
      result_next.first_result  = cell_at(square, pos_a.row, pos_b.col);
      result_next.second_result = cell_at(square, pos_b.row, pos_a.col);
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// File: rtl/pf_checker.sv
// port-level checker for the playfair digraph cipher core, bound to the top level
// depends on pf_pkg and playfair_digraph_cipher_core
module pf_checker import pf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // every accepted beat gives exactly one result strobe, registered through lane_valid and then done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2)) |-> (done == $past(start && !busy, 2)))
    else $error("result strobe does not follow accepted beat");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.letter_absent) |->
      (result.first_result == '0 && result.second_result == '0))
    else $error("absent letter with non-zero result");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // no strobe on the first cycle out of reset
  a_no_strobe_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("result strobe straight after reset");

endmodule

bind playfair_digraph_cipher_core pf_checker u_pf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
